/* sv/vis_pkg.sv */
// ----------------------------------------------------------------------------
// vis_pkg: shared types and constants of the grid value iteration sweep
// Configuration layout, register indexes, controller/datapath command and
// status groups, fixed-point constants and the per-cell step schedule.
// ----------------------------------------------------------------------------
package vis_pkg;

  // configuration register file contents
  typedef struct packed {
    logic [15:0] discount;
    logic [15:0] reach;
    logic [15:0] stray;
    logic [7:0]  high_goal;
    logic [7:0]  low_goal;
    logic [7:0]  deep_pit;
    logic [7:0]  shallow_pit;
  } vis_cfg_t;

  // register index, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_DISCOUNT    = 3'd0,
    REG_REACH       = 3'd1,
    REG_STRAY       = 3'd2,
    REG_HIGH_GOAL   = 3'd3,
    REG_LOW_GOAL    = 3'd4,
    REG_DEEP_PIT    = 3'd5,
    REG_SHALLOW_PIT = 3'd6
  } vis_reg_e;

  localparam logic [15:0] RST_DISCOUNT    = 16'd58982;
  localparam logic [15:0] RST_REACH       = 16'd45875;
  localparam logic [15:0] RST_STRAY       = 16'd6554;
  localparam logic [7:0]  RST_HIGH_GOAL   = 8'd135;
  localparam logic [7:0]  RST_LOW_GOAL    = 8'd114;
  localparam logic [7:0]  RST_DEEP_PIT    = 8'd55;
  localparam logic [7:0]  RST_SHALLOW_PIT = 8'd52;

  // input transaction kinds
  localparam logic ACT_SWEEP = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Q16.16 constants
  localparam logic signed [31:0] HIGH_GOAL_VALUE = 32'sd655360;
  localparam logic signed [31:0] LOW_GOAL_VALUE  = 32'sd196608;
  localparam logic signed [39:0] DEEP_PENALTY    = 40'sd655360;
  localparam logic signed [39:0] SHALLOW_PENALTY = 40'sd327680;

  // per-cell step schedule
  localparam logic [3:0] STEP_RD_LAST    = 4'd3;
  localparam logic [3:0] STEP_MUL_FIRST  = 4'd1;
  localparam logic [3:0] STEP_MUL_LAST   = 4'd4;
  localparam logic [3:0] STEP_TERM_FIRST = 4'd2;
  localparam logic [3:0] STEP_TERM_LAST  = 4'd5;
  localparam logic [3:0] STEP_TOTAL      = 4'd6;
  localparam logic [3:0] STEP_PROD_FIRST = 4'd7;
  localparam logic [3:0] STEP_PROD_LAST  = 4'd10;
  localparam logic [3:0] STEP_ACC_FIRST  = 4'd8;
  localparam logic [3:0] STEP_ACC_LAST   = 4'd11;
  localparam logic [3:0] STEP_LAST       = 4'd12;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;   // latch read coordinates
    logic       rd_en;     // issue neighbor read
    logic [1:0] rd_dir;
    logic       mul_en;    // discount times neighbor value
    logic       term_en;   // round to move outcome
    logic [1:0] term_dir;
    logic       tot_en;    // stray weight times outcome total
    logic       prod_en;   // weight difference times chosen outcome
    logic [1:0] act;
    logic       acc_en;    // round action value, keep the best
    logic       acc_first;
    logic       wr_en;     // write cell, advance position
    logic       finish;    // swap tables, count sweep
    logic       look_rd;   // issue lookup read
    logic       look_cap;  // capture lookup data
    logic       out_load;  // load output register
  } vis_cmd_t;

  typedef struct packed {
    logic last_cell;
  } vis_status_t;

endpackage

/* sv/vis_ram.sv */
// ----------------------------------------------------------------------------
// vis_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/vis_regs.sv */
// ----------------------------------------------------------------------------
// vis_regs: configuration register file
// APB-style access; one register per 32-bit word.
// ----------------------------------------------------------------------------
module vis_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output vis_pkg::vis_cfg_t cfg_o
);
  import vis_pkg::*;

  vis_cfg_t cfg_q, cfg_d;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (vis_reg_e'(paddr[4:2]))
        REG_DISCOUNT:    cfg_d.discount    = pwdata[15:0];
        REG_REACH:       cfg_d.reach       = pwdata[15:0];
        REG_STRAY:       cfg_d.stray       = pwdata[15:0];
        REG_HIGH_GOAL:   cfg_d.high_goal   = pwdata[7:0];
        REG_LOW_GOAL:    cfg_d.low_goal    = pwdata[7:0];
        REG_DEEP_PIT:    cfg_d.deep_pit    = pwdata[7:0];
        REG_SHALLOW_PIT: cfg_d.shallow_pit = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (vis_reg_e'(paddr[4:2]))
      REG_DISCOUNT:    prdata = {16'd0, cfg_q.discount};
      REG_REACH:       prdata = {16'd0, cfg_q.reach};
      REG_STRAY:       prdata = {16'd0, cfg_q.stray};
      REG_HIGH_GOAL:   prdata = {24'd0, cfg_q.high_goal};
      REG_LOW_GOAL:    prdata = {24'd0, cfg_q.low_goal};
      REG_DEEP_PIT:    prdata = {24'd0, cfg_q.deep_pit};
      REG_SHALLOW_PIT: prdata = {24'd0, cfg_q.shallow_pit};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.discount    <= RST_DISCOUNT;
      cfg_q.reach       <= RST_REACH;
      cfg_q.stray       <= RST_STRAY;
      cfg_q.high_goal   <= RST_HIGH_GOAL;
      cfg_q.low_goal    <= RST_LOW_GOAL;
      cfg_q.deep_pit    <= RST_DEEP_PIT;
      cfg_q.shallow_pit <= RST_SHALLOW_PIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/vis_ctrl.sv */
// ----------------------------------------------------------------------------
// vis_ctrl: sweep and lookup sequencer
// Walks the per-cell step schedule, drives the input and output handshakes.
// ----------------------------------------------------------------------------
module vis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_action_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  vis_pkg::vis_status_t status_i,
  output vis_pkg::vis_cmd_t    cmd_o
);
  import vis_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SWEEP     = 5'b00010,
    ST_LOOK_ADDR = 5'b00100,
    ST_LOOK_DATA = 5'b01000,
    ST_DONE      = 5'b10000
  } vis_state_e;

  vis_state_e state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       m_valid_q, m_valid_d;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    m_valid_d = m_valid_q & ~m_tready_i;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          step_d        = '0;
          state_d       = (s_action_i == ACT_READ) ? ST_LOOK_ADDR : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.rd_en     = (step_q <= STEP_RD_LAST);
        cmd_o.rd_dir    = step_q[1:0];
        cmd_o.mul_en    = (step_q >= STEP_MUL_FIRST) && (step_q <= STEP_MUL_LAST);
        cmd_o.term_en   = (step_q >= STEP_TERM_FIRST) && (step_q <= STEP_TERM_LAST);
        cmd_o.term_dir  = 2'(step_q - STEP_TERM_FIRST);
        cmd_o.tot_en    = (step_q == STEP_TOTAL);
        cmd_o.prod_en   = (step_q >= STEP_PROD_FIRST) && (step_q <= STEP_PROD_LAST);
        cmd_o.act       = 2'(step_q - STEP_PROD_FIRST);
        cmd_o.acc_en    = (step_q >= STEP_ACC_FIRST) && (step_q <= STEP_ACC_LAST);
        cmd_o.acc_first = (step_q == STEP_ACC_FIRST);
        if (step_q == STEP_LAST) begin
          cmd_o.wr_en = 1'b1;
          step_d      = '0;
          if (status_i.last_cell) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_DONE;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_LOOK_ADDR: begin
        cmd_o.look_rd = 1'b1;
        state_d       = ST_LOOK_DATA;
      end
      ST_LOOK_DATA: begin
        cmd_o.look_cap = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!m_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          m_valid_d      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

/* sv/vis_dp.sv */
// ----------------------------------------------------------------------------
// vis_dp: value tables and arithmetic datapath
// Two ping-pong value tables, neighbor addressing, shared multiply steps,
// best-action selection, sweep counter and output register.
// ----------------------------------------------------------------------------
module vis_dp #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vis_pkg::vis_cfg_t    cfg_i,
  input  vis_pkg::vis_cmd_t    cmd_i,
  input  logic [3:0]           cell_row_i,
  input  logic [3:0]           cell_col_i,
  output vis_pkg::vis_status_t status_o,
  output logic [47:0]          out_o
);
  import vis_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int CW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int KW    = $clog2(COLS);
  localparam int XW    = (CW > 8) ? CW : 8;

  // control state
  logic          cur_q;      // 1: table b holds current values
  logic          a_zero_q;   // table a never written since reset
  logic [15:0]   cnt_q;
  logic [RW-1:0] row_q;
  logic [KW-1:0] col_q;
  logic [CW-1:0] idx_q;

  // payload
  logic [CW-1:0]        look_addr_q;
  logic                 look_ok_q;
  logic                 rd_edge_q, mul_edge_q;
  logic signed [48:0]   mul_q;
  logic signed [33:0]   t_q [4];
  logic signed [35:0]   tot_q;
  logic signed [52:0]   st_q;
  logic signed [50:0]   prod_q;
  logic signed [31:0]   best_q;
  logic signed [31:0]   res_q;
  logic [47:0]          out_q;

  logic [CW-1:0]      nb_addr, raddr;
  logic               nb_edge;
  logic [31:0]        rd_a, rd_b;
  logic signed [31:0] v;
  logic signed [31:0] wdata;
  logic               we_a, we_b;

  // ---------------- neighbor address ----------------
  always_comb begin
    case (cmd_i.rd_dir)
      2'd0: begin
        nb_edge = (row_q == '0);
        nb_addr = nb_edge ? idx_q : CW'(idx_q - CW'(COLS));
      end
      2'd1: begin
        nb_edge = (col_q == KW'(COLS - 1));
        nb_addr = nb_edge ? idx_q : CW'(idx_q + 1'b1);
      end
      2'd2: begin
        nb_edge = (row_q == RW'(ROWS - 1));
        nb_addr = nb_edge ? idx_q : CW'(idx_q + CW'(COLS));
      end
      default: begin
        nb_edge = (col_q == '0);
        nb_addr = nb_edge ? idx_q : CW'(idx_q - 1'b1);
      end
    endcase
  end

  assign raddr = cmd_i.look_rd ? look_addr_q : nb_addr;

  // ---------------- tables ----------------
  assign we_a  = cmd_i.wr_en & cur_q;
  assign we_b  = cmd_i.wr_en & ~cur_q;

  vis_ram #(.WIDTH(32), .DEPTH(CELLS)) u_table_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  vis_ram #(.WIDTH(32), .DEPTH(CELLS)) u_table_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  assign v = cur_q ? $signed(rd_b) : (a_zero_q ? 32'sd0 : $signed(rd_a));

  // ---------------- arithmetic ----------------
  logic signed [48:0] disc_x, v_x, mr;
  logic signed [33:0] term;
  logic signed [52:0] stray_x, tot_x;
  logic signed [50:0] diff_x, ta_x;
  logic signed [16:0] diff;
  logic signed [55:0] sum, sr;
  logic signed [39:0] qv, pen;
  logic signed [31:0] qs;
  logic               hit_deep, hit_shallow, hit_low, hit_high;

  assign disc_x = {33'd0, cfg_i.discount};
  assign v_x    = {{17{v[31]}}, v};

  // round half up: add one half, drop the fraction
  assign mr   = mul_q + 49'sd32768;
  assign term = {mr[48], mr[48:16]} - (mul_edge_q ? 34'sd65536 : 34'sd0);

  assign stray_x = {37'd0, cfg_i.stray};
  assign tot_x   = {{17{tot_q[35]}}, tot_q};
  assign diff    = $signed({1'b0, cfg_i.reach}) - $signed({1'b0, cfg_i.stray});
  assign diff_x  = {{34{diff[16]}}, diff};
  assign ta_x    = {{17{t_q[cmd_i.act][33]}}, t_q[cmd_i.act]};

  assign hit_deep    = (XW'(idx_q) == XW'(cfg_i.deep_pit));
  assign hit_shallow = (XW'(idx_q) == XW'(cfg_i.shallow_pit));
  assign hit_low     = (XW'(idx_q) == XW'(cfg_i.low_goal));
  assign hit_high    = (XW'(idx_q) == XW'(cfg_i.high_goal));

  assign sum = {{3{st_q[52]}}, st_q} + {{5{prod_q[50]}}, prod_q};
  assign sr  = sum + 56'sd32768;
  assign pen = (hit_deep ? DEEP_PENALTY : 40'sd0) + (hit_shallow ? SHALLOW_PENALTY : 40'sd0);
  assign qv  = sr[55:16] - pen;

  always_comb begin
    if (qv > 40'sd2147483647) begin
      qs = 32'sh7fffffff;
    end else if (qv < -40'sd2147483648) begin
      qs = 32'sh80000000;
    end else begin
      qs = qv[31:0];
    end
  end

  always_comb begin
    if (hit_low) begin
      wdata = LOW_GOAL_VALUE;
    end else if (hit_high) begin
      wdata = HIGH_GOAL_VALUE;
    end else begin
      wdata = best_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      look_ok_q   <= (32'(cell_row_i) < ROWS) && (32'(cell_col_i) < COLS);
      look_addr_q <= CW'(32'(cell_row_i) * COLS + 32'(cell_col_i));
    end
    if (cmd_i.rd_en) begin
      rd_edge_q <= nb_edge;
    end
    if (cmd_i.mul_en) begin
      mul_q      <= disc_x * v_x;
      mul_edge_q <= rd_edge_q;
    end
    if (cmd_i.term_en) begin
      t_q[cmd_i.term_dir] <= term;
      tot_q <= (cmd_i.term_dir == 2'd0) ? 36'(term) : tot_q + 36'(term);
    end
    if (cmd_i.tot_en) begin
      st_q <= stray_x * tot_x;
    end
    if (cmd_i.prod_en) begin
      prod_q <= diff_x * ta_x;
    end
    if (cmd_i.acc_en && (cmd_i.acc_first || qs > best_q)) begin
      best_q <= qs;
    end
    if (cmd_i.look_cap) begin
      res_q <= look_ok_q ? v : 32'sd0;
    end else if (cmd_i.finish) begin
      res_q <= 32'sd0;
    end
    if (cmd_i.out_load) begin
      out_q <= {cnt_q, res_q};
    end
  end

  // ---------------- position, table select, sweep count ----------------
  assign status_o.last_cell = (idx_q == CW'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= 1'b0;
      a_zero_q <= 1'b1;
      cnt_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.wr_en) begin
        if (status_o.last_cell) begin
          row_q <= '0;
          col_q <= '0;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
          if (col_q == KW'(COLS - 1)) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
      end
      if (cmd_i.finish) begin
        cur_q <= ~cur_q;
        if (cur_q) begin
          a_zero_q <= 1'b0;
        end
        if (cnt_q != 16'hffff) begin
          cnt_q <= cnt_q + 16'd1;
        end
      end
    end
  end

  assign out_o = out_q;

endmodule

/* sv/grid_value_iteration_sweep.sv */
// ----------------------------------------------------------------------------
// grid_value_iteration_sweep: value iteration engine over a grid world
// Keeps a table of Q16.16 state values; a sweep rebuilds every cell from the
// previous table, a read returns one cell.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tuser: action; tdata: cell_row, cell_col
//  m_axis   | out       | tdata: cell_value, sweeps_done
//  apb      | in/out    | seven configuration registers at 4*i
//
//  A read passes the look-address and look-data states from acceptance to the
//  output register. In a sweep each cell goes through 13 steps of one shared
//  table read port and shared multiply stages.
//  Reset clears the counters and table select; table a reads as zero until a
//  sweep first writes it, so no clearing pass is needed.
//  One item is worked on at a time; a finished result waits in the output
//  register while the next item is accepted.
// ----------------------------------------------------------------------------
module grid_value_iteration_sweep #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] cell_row, [7:4] cell_col
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] cell_value, [47:32] sweeps_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vis_pkg::*;

  vis_cfg_t    cfg;
  vis_cmd_t    cmd;
  vis_status_t status;

  vis_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vis_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .cell_row_i (s_axis_tdata[3:0]),
    .cell_col_i (s_axis_tdata[7:4]),
    .status_o   (status),
    .out_o      (m_axis_tdata)
  );

endmodule
